// ===== rtl/aes_pkg.sv =====
package aes_pkg;

   localparam int NUM_ROUNDS = 10;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = 1'b1;

   typedef struct packed {
      logic [63:0] plain_high;
      logic [63:0] plain_low;
   } req_type;

   typedef struct packed {
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
   } rsp_type;

   typedef logic [127:0] block_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
   };

   localparam logic [7:0] RCON [NUM_ROUNDS] = '{
      8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1B,8'h36
   };

   // byte k of a block: bits 127-8k downto 120-8k
   function automatic logic [7:0] gf_double(input logic [7:0] v);
      logic [7:0] d;
      d = {v[6:0], 1'b0};
      if (v[7]) d = d ^ 8'h1B;
      return d;
   endfunction

   function automatic block_type sub_shift(input block_type b);
      block_type t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127-8*(4*c+r) -: 8] = SBOX[b[127-8*(4*((c+r)%4)+r) -: 8]];
         end
      end
      return t;
   endfunction

   function automatic block_type mix_columns(input block_type b);
      block_type t;
      logic [7:0] a0, a1, a2, a3, s;
      for (int c = 0; c < 4; c++) begin
         a0 = b[127-32*c -: 8];
         a1 = b[119-32*c -: 8];
         a2 = b[111-32*c -: 8];
         a3 = b[103-32*c -: 8];
         s  = a0 ^ a1 ^ a2 ^ a3;
         t[127-32*c -: 8] = a0 ^ s ^ gf_double(a0 ^ a1);
         t[119-32*c -: 8] = a1 ^ s ^ gf_double(a1 ^ a2);
         t[111-32*c -: 8] = a2 ^ s ^ gf_double(a2 ^ a3);
         t[103-32*c -: 8] = a3 ^ s ^ gf_double(a3 ^ a0);
      end
      return t;
   endfunction

   function automatic block_type next_key(input block_type k, input logic [7:0] rc);
      block_type n;
      logic [31:0] t;
      t = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
      n[127:96] = k[127:96] ^ t;
      n[95:64]  = k[95:64] ^ n[127:96];
      n[63:32]  = k[63:32] ^ n[95:64];
      n[31:0]   = k[31:0] ^ n[63:32];
      return n;
   endfunction

endpackage

// ===== rtl/aes_key_sched.sv =====
module aes_key_sched (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [aes_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                   csr_wr_data,
   output aes_pkg::block_type            cipher_key
);
   import aes_pkg::*;

   logic [63:0] key_high_ff, key_low_ff;

   // hold the cipher key; round keys are expanded alongside each block
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else begin
         if (csr_wr_en && csr_index == CSR_KEY_HIGH) key_high_ff <= csr_wr_data;
         if (csr_wr_en && csr_index == CSR_KEY_LOW)  key_low_ff  <= csr_wr_data;
      end
   end

   assign cipher_key = {key_high_ff, key_low_ff};
endmodule

// ===== rtl/aes_round.sv =====
module aes_round (
   input  aes_pkg::block_type state_in,
   input  aes_pkg::block_type round_key,
   input  logic               last_round,
   output aes_pkg::block_type state_out
);
   import aes_pkg::*;

   block_type ss;

   always_comb begin
      ss = sub_shift(state_in);
      state_out = (last_round ? ss : mix_columns(ss)) ^ round_key;
   end
endmodule

// ===== rtl/aes128_block_encrypt.sv =====
// AES-128 encryption pipeline, one 128-bit block per beat.
// Input beats arrive on req_ (valid/ready), ciphertext leaves on rsp_.
// The key is written over csr_: index 0 is key bytes 0..7, index 1 bytes
// 8..15. A key write applies to every beat accepted after the write edge;
// the pipe need not drain first, since each block carries its own round key
// down the pipe and expands the next one in every round stage.
// Datapath: an input register with AddRoundKey, then ten round stages,
// one per AES round, each a register. A beat accepted into the input
// register moves through the ten round registers in order and raises
// rsp_valid from the last one. Throughput is one block per cycle while
// rsp_ready is high. Stall: when rsp_ready is low the full stages hold;
// bubbles still collapse, since a stage advances whenever the one after
// it is free. req_ready drops only once all eleven stages hold a block and
// rsp_ready is low. Reset clears all valid bits and both key registers.
module aes128_block_encrypt (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  aes_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output aes_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [aes_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]      csr_wr_data
);
   import aes_pkg::*;

   localparam int STAGES = NUM_ROUNDS + 1;

   block_type cipher_key;
   block_type rk [STAGES];
   block_type kk_ff [NUM_ROUNDS];
   block_type st_ff [STAGES];
   block_type st_in [STAGES];
   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] adv;

   aes_key_sched u_key (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cipher_key  (cipher_key)
   );

   // advance a stage when it is empty or its successor moves
   always_comb begin
      adv[STAGES-1] = !vld_ff[STAGES-1] || rsp_ready;
      for (int s = STAGES-2; s >= 0; s--) begin
         adv[s] = !vld_ff[s] || adv[s+1];
      end
   end

   assign req_ready = adv[0];

   // round key 0 is the cipher key itself; each stage derives its own
   // round key from the one carried in the stage before
   assign rk[0] = cipher_key;

   generate
      for (genvar g = 1; g < STAGES; g++) begin : g_round
         assign rk[g] = next_key(kk_ff[g-1], RCON[g-1]);
         aes_round u_round (
            .state_in   (st_ff[g-1]),
            .round_key  (rk[g]),
            .last_round (g == NUM_ROUNDS),
            .state_out  (st_in[g])
         );
      end
   endgenerate

   assign st_in[0] = {req_data.plain_high, req_data.plain_low} ^ rk[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= req_valid;
         for (int s = 1; s < STAGES; s++) begin
            if (adv[s]) vld_ff[s] <= vld_ff[s-1];
         end
      end
      for (int s = 0; s < STAGES; s++) begin
         if (adv[s]) st_ff[s] <= st_in[s];
      end
      // carry the round key with its block; the last stage needs none
      for (int s = 0; s < NUM_ROUNDS; s++) begin
         if (adv[s]) kk_ff[s] <= rk[s];
      end
   end

   assign rsp_valid = vld_ff[STAGES-1];
   assign rsp_data  = {st_ff[STAGES-1][127:64], st_ff[STAGES-1][63:0]};

   // a waiting result holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // a full pipe under stall takes nothing
   assert property (@(posedge clock) disable iff (reset)
      (&vld_ff) && !rsp_ready |-> !req_ready)
      else $error("accept into full stalled pipe");

   // an accepted beat lands in the first stage
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted beat lost");

   // nothing is offered right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

// ===== bench/tb_aes128_block_encrypt.sv =====
module tb_aes128_block_encrypt;
   import aes_pkg::*;

   localparam int NUM_RANDOM = 1800;
   localparam int IDLE_LIMIT = 20000;
   localparam int KEY_SETTLE = 16;
   localparam int DRAIN_WAIT = 40;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [63:0] csr_wr_data;

   aes128_block_encrypt uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   // S-box, kept locally so the prediction does not lean on the design's package tables
   logic [7:0] sbox_lut [256];
   initial begin
      logic [7:0] p, q, x;
      // build the S-box from its field definition: multiplicative inverse + affine map
      p = 8'h01;
      q = 8'h01;
      do begin
         p = p ^ {p[6:0], 1'b0} ^ (p[7] ? 8'h1B : 8'h00);
         q = q ^ {q[6:0], 1'b0};
         q = q ^ {q[5:0], 2'b0};
         q = q ^ {q[3:0], 4'b0};
         if (q[7]) q = q ^ 8'h09;
         x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]} ^ {q[3:0], q[7:4]};
         sbox_lut[p] = x ^ 8'h63;
      end while (p != 8'h01);
      sbox_lut[0] = 8'h63;
   end

   // key registers as the block should hold them
   logic [63:0] key_hi_model;
   logic [63:0] key_lo_model;

   rsp_type cipher_queue [$];
   int errors;
   int idle_cycles;

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
   endfunction

   function automatic logic [7:0] blk_byte(input logic [127:0] b, input int k);
      return b[127-8*k -: 8];
   endfunction

   // full AES-128 encryption of one block under the modeled key
   function automatic rsp_type encrypt_block(input req_type pt);
      logic [127:0] rk [11];
      logic [127:0] s, t;
      logic [31:0] w;
      logic [7:0] rc, a0, a1, a2, a3, all;
      rsp_type ct;
      rk[0] = {key_hi_model, key_lo_model};
      rc = 8'h01;
      for (int r = 1; r <= 10; r++) begin
         w = rk[r-1][31:0];
         w = {sbox_lut[w[23:16]] ^ rc, sbox_lut[w[15:8]], sbox_lut[w[7:0]],
              sbox_lut[w[31:24]]};
         rc = xtime(rc);
         rk[r][127:96] = rk[r-1][127:96] ^ w;
         rk[r][95:64] = rk[r-1][95:64] ^ rk[r][127:96];
         rk[r][63:32] = rk[r-1][63:32] ^ rk[r][95:64];
         rk[r][31:0] = rk[r-1][31:0] ^ rk[r][63:32];
      end
      s = {pt.plain_high, pt.plain_low} ^ rk[0];
      for (int r = 1; r <= 10; r++) begin
         // sub bytes and shift rows in one pass
         for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++)
               t[127-8*(4*c+j) -: 8] = sbox_lut[blk_byte(s, 4*((c+j)%4)+j)];
         s = t;
         if (r != 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = blk_byte(t, 4*c);
               a1 = blk_byte(t, 4*c+1);
               a2 = blk_byte(t, 4*c+2);
               a3 = blk_byte(t, 4*c+3);
               all = a0 ^ a1 ^ a2 ^ a3;
               s[127-32*c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
               s[119-32*c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
               s[111-32*c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
               s[103-32*c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
            end
         end
         s = s ^ rk[r];
      end
      ct.cipher_high = s[127:64];
      ct.cipher_low = s[63:0];
      return ct;
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver idling: random stalls, a quiet stretch, and one long hold-off
   bit rsp_quiet;
   bit rsp_hold;
   always @(negedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else if (rsp_hold)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= rsp_quiet || ($urandom_range(99) >= 9);
   end

   // compare each accepted beat with the oldest expected ciphertext
   always @(posedge clock) begin
      rsp_type exp_ct;
      if (!reset && rsp_valid && rsp_ready) begin
         if (cipher_queue.size() == 0) begin
            $error("unexpected result beat %h", rsp_data);
            errors++;
         end else begin
            exp_ct = cipher_queue.pop_front();
            if (rsp_data.cipher_high !== exp_ct.cipher_high) begin
               $error("cipher_high expected %h actual %h",
                      exp_ct.cipher_high, rsp_data.cipher_high);
               errors++;
            end
            if (rsp_data.cipher_low !== exp_ct.cipher_low) begin
               $error("cipher_low expected %h actual %h",
                      exp_ct.cipher_low, rsp_data.cipher_low);
               errors++;
            end
         end
      end
   end

   // watchdog: count cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   bit req_quiet;

   // offer one beat, hold it until accepted, queue its typed or predicted ciphertext;
   // valid stays up after the accept so the next beat can follow directly
   task automatic send_block(input req_type pt, input bit check_typed, input rsp_type typed_ct);
      rsp_type ct;
      while (!req_quiet && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data <= pt;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ct = encrypt_block(pt);
      if (check_typed) ct = typed_ct;
      cipher_queue.push_back(ct);
      @(negedge clock);
   endtask

   // key write at the falling edge, only with the pipe empty
   task automatic write_key(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      req_valid <= 1'b0;
      while (cipher_queue.size() != 0) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      if (idx == CSR_KEY_HIGH) key_hi_model = val;
      else key_lo_model = val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   typedef struct {
      bit          set_key;
      logic [63:0] k_hi;
      logic [63:0] k_lo;
      req_type     pt;
      bit          typed;
      rsp_type     ct;
   } stim_row;

   stim_row dir_rows [9] = '{
      // FIPS-197 appendix C.1 vector
      '{1'b1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
        '{64'h0011223344556677, 64'h8899aabbccddeeff},
        1'b1, '{64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a}},
      // FIPS-197 appendix B vector
      '{1'b1, 64'h2b7e151628aed2a6, 64'habf7158809cf4f3c,
        '{64'h3243f6a8885a308d, 64'h313198a2e0370734},
        1'b1, '{64'h3925841d02dc09fb, 64'hdc118597196a0b32}},
      // all-zero key and block
      '{1'b1, 64'h0, 64'h0, '{64'h0, 64'h0},
        1'b1, '{64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e}},
      '{1'b0, 64'h0, 64'h0, '{64'hffffffffffffffff, 64'hffffffffffffffff}, 1'b0, '{64'h0, 64'h0}},
      '{1'b0, 64'h0, 64'h0, '{64'h8000000000000000, 64'h0000000000000001}, 1'b0, '{64'h0, 64'h0}},
      '{1'b1, 64'hffffffffffffffff, 64'hffffffffffffffff,
        '{64'h0, 64'h0}, 1'b0, '{64'h0, 64'h0}},
      '{1'b0, 64'h0, 64'h0, '{64'hffffffffffffffff, 64'hffffffffffffffff}, 1'b0, '{64'h0, 64'h0}},
      '{1'b0, 64'h0, 64'h0, '{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555}, 1'b0, '{64'h0, 64'h0}},
      '{1'b1, 64'h8000000000000000, 64'h0000000000000001,
        '{64'h0123456789abcdef, 64'hfedcba9876543210}, 1'b0, '{64'h0, 64'h0}}
   };

   initial begin
      req_type pt;
      errors = 0;
      idle_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_KEY_HIGH;
      csr_wr_data = '0;
      rsp_quiet = 1'b0;
      rsp_hold = 1'b0;
      req_quiet = 1'b0;
      key_hi_model = '0;
      key_lo_model = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (KEY_SETTLE) @(negedge clock);

      // right after reset the key is zero: typed expectation
      send_block('{64'h0, 64'h0}, 1'b1, '{64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e});

      // walk the directed table
      foreach (dir_rows[i]) begin
         if (dir_rows[i].set_key) begin
            write_key(CSR_KEY_HIGH, dir_rows[i].k_hi);
            write_key(CSR_KEY_LOW, dir_rows[i].k_lo);
         end
         send_block(dir_rows[i].pt, dir_rows[i].typed, dir_rows[i].ct);
      end

      // random blocks in phases, a fresh random key for each phase after the first
      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            write_key(CSR_KEY_HIGH, {$urandom, $urandom});
            write_key(CSR_KEY_LOW, {$urandom, $urandom});
         end
         // phase 2: no idling on either side; phase 3: long receiver hold-off
         req_quiet = (ph == 2);
         rsp_quiet = (ph == 2);
         if (ph == 3) begin
            fork
               begin
                  rsp_hold = 1'b1;
                  repeat (200) @(posedge clock);
                  rsp_hold = 1'b0;
               end
            join_none
         end
         for (int n = 0; n < NUM_RANDOM / 6; n++) begin
            pt.plain_high = {$urandom, $urandom};
            pt.plain_low = {$urandom, $urandom};
            send_block(pt, 1'b0, '{64'h0, 64'h0});
         end
      end
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
      req_valid <= 1'b0;

      // drain
      while (cipher_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      if (errors == 0 && cipher_queue.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
